// File: design/vnc_pkg.sv
// ----------------------------------------------------------------------------
// vnc_pkg
// Shared types and constants for the voxel nearest-to-center filter.
// ----------------------------------------------------------------------------
package vnc_pkg;

  // default voxel store depth
  localparam int GRID_ENTRIES_DEF = 4096;

  // field widths
  localparam int COORD_W = 32;
  localparam int LEAF_W  = 31;
  localparam int CELLS_W = 13;
  localparam int VIDX_W  = 12;
  localparam int CIDX_W  = 3;
  localparam int STAT_W  = 3;

  // quotient bits produced by the serial divider (cells < 2^13)
  localparam int QBITS = CELLS_W;

  // stored word: occupied flag and three coordinates
  localparam int WORD_W = 1 + 3 * COORD_W;

  // register reset values
  localparam logic [LEAF_W-1:0]  LEAF_RST  = 31'd65536;
  localparam logic [CELLS_W-1:0] CELLS_RST = 13'd16;

  // saturation cap for offset magnitudes
  localparam logic [35:0] MAG_CAP = 36'h0_8000_0000;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_LEAF     = 3'd3,
    CFG_CELLS_X  = 3'd4,
    CFG_CELLS_Y  = 3'd5,
    CFG_CELLS_Z  = 3'd6
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NEW      = 3'd0,
    ST_REPLACED = 3'd1,
    ST_KEPT     = 3'd2,
    ST_OUTSIDE  = 3'd3,
    ST_RD_EMPTY = 3'd4,
    ST_RD_OCC   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_LIN,
    S_RD,
    S_RDW,
    S_SQ,
    S_DONE
  } fsm_t;

endpackage

// File: design/vnc_in_if.sv
// ----------------------------------------------------------------------------
// vnc_in_if
// Input item channel: insert a point or read and clear one voxel.
// ----------------------------------------------------------------------------
interface vnc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic        [11:0] read_index;

  modport source (output valid, operation, point_x, point_y, point_z, read_index,
                  input ready);
  modport sink   (input valid, operation, point_x, point_y, point_z, read_index,
                  output ready);
endinterface

// File: design/vnc_out_if.sv
// ----------------------------------------------------------------------------
// vnc_out_if
// Result channel: one word per accepted input item.
// ----------------------------------------------------------------------------
interface vnc_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic        [11:0] voxel_index;
  logic signed [31:0] kept_x;
  logic signed [31:0] kept_y;
  logic signed [31:0] kept_z;

  modport source (output valid, status, voxel_index, kept_x, kept_y, kept_z,
                  input ready);
  modport sink   (input valid, status, voxel_index, kept_x, kept_y, kept_z,
                  output ready);
endinterface

// File: design/vnc_cfg_if.sv
// ----------------------------------------------------------------------------
// vnc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface vnc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/vnc_ram.sv
// ----------------------------------------------------------------------------
// vnc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/voxel_nearest_to_center_filter_top.sv
// ----------------------------------------------------------------------------
// voxel_nearest_to_center_filter_top
// Voxel-grid filter keeping, per voxel, the point nearest the voxel center.
// ----------------------------------------------------------------------------
// Channels: in_ch takes insert or read words, out_ch returns one result word
// per input word, cfg_ch writes the grid registers (always ready; write only
// while the block is idle).
// One item is in work at a time. An insert runs the radix-2 divider (all
// three axes in parallel), the linear index on the shared multiplier, the
// voxel RAM read, the six squares on the same multiplier when the voxel is
// occupied, and a retire step; a point outside the grid goes from the
// linear index to retire. A read runs the voxel RAM read and retire; the
// single-port-read RAM and the one shared 32x32 multiplier set these steps.
// The result sits in an output register; the next input word is taken while
// it waits. If the receiver stalls, a finished item waits in the retire
// state until the output register frees, and no further word is taken.
// After reset the block sweeps the voxel RAM to clear occupancy, one entry a
// cycle through every entry, with in_ch not ready; config writes still go.
// ----------------------------------------------------------------------------
module voxel_nearest_to_center_filter_top import vnc_pkg::*; #(
  parameter int GRID_ENTRIES = GRID_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vnc_in_if.sink    in_ch,
  vnc_out_if.source out_ch,
  vnc_cfg_if.sink   cfg_ch
);

  localparam int AW   = $clog2(GRID_ENTRIES);
  localparam int LINW = 40;

  // configuration registers
  logic signed [COORD_W-1:0] org_r [3];
  logic [LEAF_W-1:0]         leaf_r;
  logic [CELLS_W-1:0]        cells_r [3];

  // control
  fsm_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [3:0]    bit_r;
  logic [2:0]    k_r;

  // item registers
  logic                      op_r;
  logic signed [COORD_W-1:0] p_r [3];
  logic [31:0]               rem_r [3];
  logic [QBITS-1:0]          q_r [3];
  logic                      oob_r;
  logic [LINW-1:0]           lin_r;
  logic [AW-1:0]             addr_r;
  logic [31:0]               mag_r [6];
  logic [63:0]               acc_n_r, acc_s_r;
  logic [63:0]               prod_r;
  logic [WORD_W-1:0]         wdata_r;
  logic                      wr_r;
  status_t                   stat_r;
  logic [VIDX_W-1:0]         vidx_r;
  logic signed [COORD_W-1:0] kept_r [3];

  // output register
  logic                      out_valid_r;
  status_t                   out_stat_r;
  logic [VIDX_W-1:0]         out_vidx_r;
  logic signed [COORD_W-1:0] out_kept_r [3];

  // ram ports
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;

  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  vnc_ram #(.WIDTH(WORD_W), .DEPTH(GRID_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  // per-axis offsets of the incoming point and range precheck
  logic signed [32:0] d_in [3];
  logic               out_in;
  always_comb begin
    out_in = (leaf_r == '0);
    d_in[0] = {in_ch.point_x[31], in_ch.point_x} - {org_r[0][31], org_r[0]};
    d_in[1] = {in_ch.point_y[31], in_ch.point_y} - {org_r[1][31], org_r[1]};
    d_in[2] = {in_ch.point_z[31], in_ch.point_z} - {org_r[2][31], org_r[2]};
    for (int a = 0; a < 3; a++) begin
      if (d_in[a][32] || ({11'b0, d_in[a]} >= {leaf_r, 13'b0})) begin
        out_in = 1'b1;
      end
    end
  end

  // divider step: one quotient bit per cycle on each axis
  logic [43:0] div_sh;
  logic [31:0] rem_nxt [3];
  logic        qbit [3];
  always_comb begin
    div_sh = 44'(leaf_r) << bit_r;
    for (int a = 0; a < 3; a++) begin
      qbit[a]    = ({12'b0, rem_r[a]} >= div_sh);
      rem_nxt[a] = qbit[a] ? (rem_r[a] - div_sh[31:0]) : rem_r[a];
    end
  end

  // grid bounds after division
  logic in_grid;
  always_comb begin
    in_grid = !oob_r;
    for (int a = 0; a < 3; a++) begin
      if (q_r[a] >= cells_r[a]) begin
        in_grid = 1'b0;
      end
    end
  end

  // offset magnitudes for the new and the stored point
  logic               occ_rd;
  logic signed [COORD_W-1:0] s_rd [3];
  logic signed [33:0] e_new [3];
  logic signed [33:0] ds [3];
  logic signed [35:0] e_st [3];
  logic [35:0]        m_st [3];
  logic [31:0]        mag_new [3];
  logic [31:0]        mag_st [3];
  always_comb begin
    occ_rd  = ram_rdata[WORD_W-1];
    s_rd[0] = ram_rdata[3*COORD_W-1:2*COORD_W];
    s_rd[1] = ram_rdata[2*COORD_W-1:COORD_W];
    s_rd[2] = ram_rdata[COORD_W-1:0];
    for (int a = 0; a < 3; a++) begin
      e_new[a]   = $signed({1'b0, rem_r[a], 1'b0}) - $signed({3'b0, leaf_r});
      mag_new[a] = e_new[a][33] ? 32'(-e_new[a]) : 32'(e_new[a]);
      ds[a]      = 34'(s_rd[a]) - 34'(p_r[a]) + $signed({2'b0, rem_r[a]});
      e_st[a]    = $signed({ds[a][33], ds[a], 1'b0}) - $signed({5'b0, leaf_r});
      m_st[a]    = e_st[a][35] ? 36'(-e_st[a]) : 36'(e_st[a]);
      mag_st[a]  = (m_st[a] > MAG_CAP) ? MAG_CAP[31:0] : m_st[a][31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == AW'(GRID_ENTRIES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.operation == OP_READ) begin
            state_nxt = ({9'b0, in_ch.read_index} < 21'(GRID_ENTRIES)) ? S_RD : S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: if (bit_r == 4'd0) state_nxt = S_LIN;
      S_LIN: begin
        if (k_r == 3'd0 && !in_grid) begin
          state_nxt = S_DONE;
        end else if (k_r == 3'd4) begin
          state_nxt = (lin_r < LINW'(GRID_ENTRIES)) ? S_RD : S_DONE;
        end
      end
      S_RD:  state_nxt = S_RDW;
      S_RDW: state_nxt = (op_r == OP_INSERT && occ_rd) ? S_SQ : S_DONE;
      S_SQ:  if (k_r == 3'd7) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    ram_re      = (state_r == S_RD);
    ram_we      = 1'b0;
    ram_waddr   = addr_r;
    ram_wdata   = wdata_r;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_LIN: begin
        case (k_r)
          3'd0: begin mul_a = 32'(q_r[2]);  mul_b = 32'(cells_r[0]); end
          3'd1: begin mul_a = prod_r[31:0]; mul_b = 32'(cells_r[1]); end
          3'd2: begin mul_a = 32'(q_r[1]);  mul_b = 32'(cells_r[0]); end
          default: ;
        endcase
      end
      S_SQ: begin
        if (k_r < 3'd6) begin
          mul_a = mag_r[k_r];
          mul_b = mag_r[k_r];
        end
      end
      S_DONE: ram_we = out_free && wr_r;
      default: ;
    endcase
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0]   <= '0;
      org_r[1]   <= '0;
      org_r[2]   <= '0;
      leaf_r     <= LEAF_RST;
      cells_r[0] <= CELLS_RST;
      cells_r[1] <= CELLS_RST;
      cells_r[2] <= CELLS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ORIGIN_X: org_r[0]   <= cfg_ch.data;
        CFG_ORIGIN_Y: org_r[1]   <= cfg_ch.data;
        CFG_ORIGIN_Z: org_r[2]   <= cfg_ch.data;
        CFG_LEAF:     leaf_r     <= cfg_ch.data[LEAF_W-1:0];
        CFG_CELLS_X:  cells_r[0] <= cfg_ch.data[CELLS_W-1:0];
        CFG_CELLS_Y:  cells_r[1] <= cfg_ch.data[CELLS_W-1:0];
        CFG_CELLS_Z:  cells_r[2] <= cfg_ch.data[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r   <= in_ch.operation;
        p_r[0] <= in_ch.point_x;
        p_r[1] <= in_ch.point_y;
        p_r[2] <= in_ch.point_z;
        for (int a = 0; a < 3; a++) begin
          rem_r[a] <= d_in[a][31:0];
          q_r[a]   <= '0;
          kept_r[a] <= '0;
        end
        oob_r  <= out_in;
        bit_r  <= 4'(QBITS - 1);
        k_r    <= '0;
        wr_r   <= 1'b0;
        vidx_r <= in_ch.read_index;
        addr_r <= AW'(in_ch.read_index);
        stat_r <= ST_RD_EMPTY;
      end
      S_DIV: begin
        for (int a = 0; a < 3; a++) begin
          rem_r[a]        <= rem_nxt[a];
          q_r[a][bit_r]   <= qbit[a];
        end
        bit_r <= bit_r - 1'b1;
      end
      S_LIN: begin
        k_r    <= k_r + 1'b1;
        stat_r <= ST_OUTSIDE;
        if (k_r == 3'd2) lin_r <= prod_r[LINW-1:0] + LINW'(q_r[0]);
        if (k_r == 3'd3) lin_r <= lin_r + prod_r[LINW-1:0];
        // index reported only when it lands in the store
        if (k_r == 3'd4 && lin_r < LINW'(GRID_ENTRIES)) begin
          addr_r <= lin_r[AW-1:0];
          vidx_r <= lin_r[VIDX_W-1:0];
        end else begin
          vidx_r <= '0;
        end
      end
      S_RDW: begin
        k_r     <= '0;
        acc_n_r <= '0;
        acc_s_r <= '0;
        if (op_r == OP_READ) begin
          wdata_r <= '0;
          wr_r    <= occ_rd;
          stat_r  <= occ_rd ? ST_RD_OCC : ST_RD_EMPTY;
          for (int a = 0; a < 3; a++) kept_r[a] <= occ_rd ? s_rd[a] : '0;
        end else if (!occ_rd) begin
          wdata_r <= {1'b1, p_r[0], p_r[1], p_r[2]};
          wr_r    <= 1'b1;
          stat_r  <= ST_NEW;
          for (int a = 0; a < 3; a++) kept_r[a] <= p_r[a];
        end else begin
          wdata_r <= {1'b1, p_r[0], p_r[1], p_r[2]};
          for (int a = 0; a < 3; a++) begin
            kept_r[a]  <= s_rd[a];
            mag_r[a]   <= mag_new[a];
            mag_r[a+3] <= mag_st[a];
          end
        end
      end
      S_SQ: begin
        k_r <= k_r + 1'b1;
        if (k_r >= 3'd1 && k_r <= 3'd3) acc_n_r <= acc_n_r + prod_r;
        if (k_r >= 3'd4 && k_r <= 3'd6) acc_s_r <= acc_s_r + prod_r;
        if (k_r == 3'd7) begin
          if (acc_n_r < acc_s_r) begin
            wr_r   <= 1'b1;
            stat_r <= ST_REPLACED;
            for (int a = 0; a < 3; a++) kept_r[a] <= p_r[a];
          end else begin
            stat_r <= ST_KEPT;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_stat_r <= stat_r;
          out_vidx_r <= vidx_r;
          for (int a = 0; a < 3; a++) out_kept_r[a] <= kept_r[a];
        end
      end
      default: ;
    endcase
  end

  // result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_stat_r;
  assign out_ch.voxel_index = out_vidx_r;
  assign out_ch.kept_x      = out_kept_r[0];
  assign out_ch.kept_y      = out_kept_r[1];
  assign out_ch.kept_z      = out_kept_r[2];

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voxel nearest-to-center filter: a scoreboard
// class predicts every result word from its own copy of the grid registers
// and voxel store, while plain tasks drive insert/read words and register
// writes under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import vnc_pkg::*;

// one predicted result word
typedef struct {
  status_t     st;
  logic [11:0] idx;
  logic [31:0] kx;
  logic [31:0] ky;
  logic [31:0] kz;
} vox_result_t;

class VoxelScoreboard;
  // grid registers
  logic signed [31:0] org_x, org_y, org_z;
  logic [30:0]        leaf;
  logic [12:0]        cnt_x, cnt_y, cnt_z;
  // voxel store
  bit                 occ [GRID_ENTRIES_DEF];
  logic [31:0]        sx [GRID_ENTRIES_DEF];
  logic [31:0]        sy [GRID_ENTRIES_DEF];
  logic [31:0]        sz [GRID_ENTRIES_DEF];
  vox_result_t        pending_q [$];
  int                 errors;
  int                 seen [6];
  int                 last_lin;

  function new();
    org_x = 0; org_y = 0; org_z = 0;
    leaf  = LEAF_RST;
    cnt_x = CELLS_RST; cnt_y = CELLS_RST; cnt_z = CELLS_RST;
    foreach (occ[i]) occ[i] = 0;
    errors = 0;
    last_lin = 0;
    foreach (seen[i]) seen[i] = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      CFG_ORIGIN_X: org_x = data;
      CFG_ORIGIN_Y: org_y = data;
      CFG_ORIGIN_Z: org_z = data;
      CFG_LEAF:     leaf  = data[30:0];
      CFG_CELLS_X:  cnt_x = data[12:0];
      CFG_CELLS_Y:  cnt_y = data[12:0];
      CFG_CELLS_Z:  cnt_z = data[12:0];
      default: ;
    endcase
  endfunction

  // cell along one axis into cell_no; returns 0 if the point falls outside
  function bit axis_cell(longint p, longint org, longint cells, output longint cell_no);
    longint d;
    d = p - org;
    cell_no = 0;
    if (leaf == 0 || d < 0) return 0;
    cell_no = d / longint'(leaf);
    return cell_no < cells;
  endfunction

  // doubled offset from the cell center, magnitude capped at 2^31
  function longint unsigned off_mag(longint p, longint org, longint cell_no);
    longint e;
    e = 2 * (p - org - cell_no * longint'(leaf)) - longint'(leaf);
    if (e < 0) e = -e;
    if (e > 64'h8000_0000) e = 64'h8000_0000;
    return longint'(e);
  endfunction

  function longint unsigned dist2(longint px, longint py, longint pz,
                                  longint cx, longint cy, longint cz);
    longint unsigned a, b, c;
    a = off_mag(px, org_x, cx);
    b = off_mag(py, org_y, cy);
    c = off_mag(pz, org_z, cz);
    return a * a + b * b + c * c;
  endfunction

  function void note_item(logic op, logic signed [31:0] px, logic signed [31:0] py,
                          logic signed [31:0] pz, logic [11:0] ridx);
    vox_result_t r;
    longint cx, cy, cz, lin;
    bit in_grid, take;
    r.st = ST_RD_EMPTY; r.idx = 0; r.kx = 0; r.ky = 0; r.kz = 0;
    if (op == OP_READ) begin
      r.idx = ridx;
      if (occ[ridx]) begin
        r.st = ST_RD_OCC;
        r.kx = sx[ridx]; r.ky = sy[ridx]; r.kz = sz[ridx];
        occ[ridx] = 0;
      end
    end else begin
      in_grid = axis_cell(px, org_x, cnt_x, cx) && axis_cell(py, org_y, cnt_y, cy) &&
                axis_cell(pz, org_z, cnt_z, cz);
      if (in_grid) begin
        lin = cz * cnt_x * cnt_y + cy * cnt_x + cx;
        in_grid = lin < GRID_ENTRIES_DEF;
      end
      if (!in_grid) begin
        r.st = ST_OUTSIDE;
      end else begin
        take = 1;
        r.st = ST_NEW;
        if (occ[lin]) begin
          take = dist2(px, py, pz, cx, cy, cz) <
                 dist2($signed(sx[lin]), $signed(sy[lin]), $signed(sz[lin]), cx, cy, cz);
          r.st = take ? ST_REPLACED : ST_KEPT;
        end
        if (take) begin
          sx[lin] = px; sy[lin] = py; sz[lin] = pz;
          occ[lin] = 1;
        end
        r.idx = lin[11:0];
        r.kx = sx[lin]; r.ky = sy[lin]; r.kz = sz[lin];
        last_lin = lin;
      end
    end
    pending_q.push_back(r);
  endfunction

  function void check_result(logic [2:0] st, logic [11:0] idx, logic [31:0] kx,
                             logic [31:0] ky, logic [31:0] kz);
    vox_result_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: result word with nothing expected: status %0d index %0d",
               $time, st, idx);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (st < 6) seen[st]++;
    if (st !== e.st) begin
      $display("%0t: status expected %0d actual %0d", $time, e.st, st); errors++;
    end
    if (idx !== e.idx) begin
      $display("%0t: voxel_index expected %0d actual %0d", $time, e.idx, idx); errors++;
    end
    if (kx !== e.kx) begin
      $display("%0t: kept_x expected %h actual %h", $time, e.kx, kx); errors++;
    end
    if (ky !== e.ky) begin
      $display("%0t: kept_y expected %h actual %h", $time, e.ky, ky); errors++;
    end
    if (kz !== e.kz) begin
      $display("%0t: kept_z expected %h actual %h", $time, e.kz, kz); errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int          IDLE_LIMIT = 30000;
  localparam logic [2:0]  CFG_NONE   = 3'd7;   // index past the register list
  localparam int          ONE        = 65536;

  // idling patterns
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic clk;
  logic rst_n;
  int   idle_mode;
  bit   quiet;
  int   stall_cnt;
  int   n_items;

  vnc_in_if  in_bus();
  vnc_out_if out_bus();
  vnc_cfg_if cfg_bus();

  VoxelScoreboard sb;

  voxel_nearest_to_center_filter_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // probability of an idle cycle for the current pattern
  function automatic bit roll_idle(bit sender);
    int pct;
    pct = 0;
    if (!quiet) begin
      case (idle_mode)
        IDLE_SEND: pct = sender ? 82 : 0;
        IDLE_RECV: pct = sender ? 0 : 82;
        IDLE_BOTH: pct = 11;
        default:   pct = 0;
      endcase
    end
    return $urandom_range(0, 99) < pct;
  endfunction

  // receiver ready
  always @(negedge clk) begin
    out_bus.ready <= !roll_idle(0);
  end

  // monitors and watchdog
  always @(posedge clk) begin
    bit moved;
    moved = 0;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.note_item(in_bus.operation, in_bus.point_x, in_bus.point_y, in_bus.point_z,
                     in_bus.read_index);
        moved = 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result(out_bus.status, out_bus.voxel_index, out_bus.kept_x,
                        out_bus.kept_y, out_bus.kept_z);
        moved = 1;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.write_reg(cfg_bus.index, cfg_bus.data);
        moved = 1;
      end
    end
    stall_cnt = moved ? 0 : stall_cnt + 1;
    if (stall_cnt >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // one input word, held until accepted
  task automatic send_word(logic op, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [11:0] ridx);
    if ((n_items % 16) == 0) quiet = ($urandom_range(0, 3) == 0);
    n_items++;
    while (roll_idle(1)) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid      = 1'b1;
    in_bus.operation  = op;
    in_bus.point_x    = px;
    in_bus.point_y    = py;
    in_bus.point_z    = pz;
    in_bus.read_index = ridx;
    do @(posedge clk); while (!(in_bus.ready));
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic insert_pt(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_word(OP_INSERT, px, py, pz, $urandom());
  endtask

  task automatic read_vox(logic [11:0] ridx);
    send_word(OP_READ, $urandom(), $urandom(), $urandom(), ridx);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // wait until every result is back, then let the datapath settle
  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] lf, logic [31:0] nx, logic [31:0] ny,
                          logic [31:0] nz);
    drain();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_LEAF, lf);
    write_reg(CFG_CELLS_X, nx);
    write_reg(CFG_CELLS_Y, ny);
    write_reg(CFG_CELLS_Z, nz);
  endtask

  // one coordinate aimed into the grid along an axis
  function automatic logic [31:0] aim_axis(longint org, longint cells);
    longint lf, cell_no, off;
    int     pick;
    lf      = sb.leaf;
    cell_no = $urandom_range(0, ((cells > 16) ? 16 : ((cells < 1) ? 1 : cells)) - 1);
    pick    = $urandom_range(0, 19);
    if (lf <= 1)        off = 0;
    else if (pick < 3)  off = lf / 2;
    else if (pick < 5)  off = lf / 2 + $urandom_range(0, 1);
    else if (pick < 7)  off = lf - 1;
    else if (pick < 8)  off = 0;
    else                off = $urandom_range(0, lf - 1);
    return 32'(org + cell_no * lf + off);
  endfunction

  task automatic random_words(int count);
    logic [31:0] px, py, pz;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        insert_pt(aim_axis(sb.org_x, sb.cnt_x), aim_axis(sb.org_y, sb.cnt_y),
                  aim_axis(sb.org_z, sb.cnt_z));
      end else if (pick < 63) begin
        // second point near the last stored one, often into the same voxel
        px = sb.sx[sb.last_lin]; py = sb.sy[sb.last_lin]; pz = sb.sz[sb.last_lin];
        if ($urandom_range(0, 1)) px = px ^ $urandom_range(0, 7);
        insert_pt(px, py, pz);
      end else if (pick < 75) begin
        insert_pt($urandom(), $urandom(), $urandom());
      end else if (pick < 88) begin
        read_vox(12'(sb.last_lin + $urandom_range(0, 2)));
      end else begin
        read_vox($urandom());
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_bus.valid = 1'b0; in_bus.operation = OP_INSERT;
    in_bus.point_x = 0; in_bus.point_y = 0; in_bus.point_z = 0; in_bus.read_index = 0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0; cfg_bus.index = CFG_ORIGIN_X; cfg_bus.data = 0;
    idle_mode = IDLE_NONE; quiet = 0; stall_cnt = 0; n_items = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset grid, 16^3 voxels of 1.0
    insert_pt(ONE / 2, ONE / 2, ONE / 2);          // exact center, new voxel
    insert_pt(0, 0, 0);                            // corner, kept
    insert_pt(ONE / 2, ONE / 2, ONE / 2);          // tie keeps stored
    insert_pt(ONE / 4, ONE / 2, ONE / 2);          // farther, kept
    insert_pt(16 * ONE - 1, 16 * ONE - 1, 16 * ONE - 1);  // last voxel
    insert_pt(15 * ONE + ONE / 2, 15 * ONE + ONE / 2, 15 * ONE + ONE / 2);  // nearer
    insert_pt(-1, 0, 0);                           // below origin
    insert_pt(16 * ONE, 0, 0);                     // past the last cell
    insert_pt(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    insert_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    read_vox(0);                                   // occupied
    read_vox(0);                                   // now empty
    read_vox(12'hfff);                             // occupied, last index
    read_vox(12'hfff);                             // empty
    insert_pt(3 * ONE, 2 * ONE, ONE);              // leave one stored point

    // registers changed with a point still stored
    set_grid(-2 * ONE, 0, 3 * ONE, ONE / 4, 4, 4, 4);
    insert_pt(3 * ONE + 1, 2 * ONE, ONE);
    insert_pt(-2 * ONE + ONE / 8, ONE / 8, 3 * ONE + ONE / 8);
    drain();
    write_reg(CFG_NONE, 32'hdead_beef);            // unlisted index, ignored
    insert_pt(-2 * ONE, 0, 3 * ONE);
    // a zero cell count puts everything outside
    set_grid(0, 0, 0, ONE, 16, 0, 16);
    insert_pt(ONE, 0, ONE);
    set_grid(0, 0, 0, 1, 4096, 1, 1);              // smallest leaf, long row
    insert_pt(4095, 0, 0);
    insert_pt(4096, 0, 0);

    // random phases across grid settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_grid(0, 0, 0, ONE, 16, 16, 16);
        1: set_grid(-2 * ONE, ONE, -3 * ONE, ONE / 2, 4, 4, 4);
        2: set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 2, 2, 1);
        3: set_grid(0, 32'h7fff_0000, 0, 3, 4096, 1, 1);
        4: set_grid(-100, -100, -100, 7, 8191, 8191, 8191);
        default: set_grid(32'h7fff_ffff, 0, 32'hffff_0000, 1, 1, 1, 1);
      endcase
      idle_mode = ph % 4;
      random_words(125);
    end

    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("covered %0d words over several grid settings: new %0d replaced %0d kept %0d",
             n_items, sb.seen[ST_NEW], sb.seen[ST_REPLACED], sb.seen[ST_KEPT]);
    $display("outside %0d, reads empty %0d, reads occupied %0d",
             sb.seen[ST_OUTSIDE], sb.seen[ST_RD_EMPTY], sb.seen[ST_RD_OCC]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
